FILE: design/smoothed_rate_of_change_top_assert.svh
// Assertion macros used by the checker file of the rate-of-change block.
`ifndef SMOOTHED_RATE_OF_CHANGE_TOP_ASSERT_SVH
`define SMOOTHED_RATE_OF_CHANGE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SROC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sroc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SROC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sroc: next-cycle check failed");

`endif

FILE: design/sroc_pkg.sv
package sroc_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int COMPONENTS = 3;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int IN_W       = 4 * DATA_W;
    localparam int OUT_W      = 3 * DATA_W;

    localparam int WIN_LEN_W  = 7;
    localparam int COMP_CNT_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    localparam int POS_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int COMP_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int CNT_W  = $clog2(COMPONENTS + 1);
    localparam int SUM_W  = DATA_W + POS_W + 1;
    localparam int ROW_W  = COMPONENTS * DATA_W;

    // Shared divider: 33 quotient bits, one per cycle.
    localparam int DIV_W      = DATA_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int REM_INIT_W = FRAC_W;

    localparam logic [CFG_IDX_W-1:0]  REG_WINDOW_LENGTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_COMPONENT_COUNT   = 8'd1;
    localparam logic [WIN_LEN_W-1:0]  RESET_WINDOW_LENGTH   = 7'd10;
    localparam logic [COMP_CNT_W-1:0] RESET_COMPONENT_COUNT = 2'd1;

    localparam logic [DATA_W-1:0] SPEED_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SPEED_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_QSTART,
        ST_QWAIT,
        ST_QDONE,
        ST_SUB,
        ST_ADD,
        ST_ASTART,
        ST_AWAIT,
        ST_ADONE,
        ST_WRITE,
        ST_PUSH
    } sroc_state_t;

    typedef struct packed {
        logic                  start;
        logic [REM_INIT_W-1:0] rem_init;
        logic [DIV_W-1:0]      dividend;
        logic [DATA_W-1:0]     divisor;
    } sroc_div_req_t;

endpackage

FILE: design/sroc_div.sv
module sroc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sroc_pkg::sroc_div_req_t       req,
    output logic                          done,
    output logic [sroc_pkg::DIV_W-1:0]    quotient
);
    import sroc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    den_reg;

    logic [DIV_W-1:0]     trial;
    logic [DIV_W-1:0]     trial_sub;
    logic                 ge;

    // Bring down the next dividend bit, subtract when it fits.
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DATA_W'(req.rem_init);
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/smoothed_rate_of_change_top.sv
// Smoothed rate of change of up to three signed Q16.16 components.
// Input stream: one transfer carries value_x, value_y, value_z and delta_time
// (unsigned Q16.16 seconds). Output stream: one transfer carries the averaged
// speeds; tuser flags that a speed quotient was clipped. An item with zero
// delta_time updates the previous sample and produces no output transfer.
// Config channel: index 0 is window_length, index 1 is component_count; a
// write to either clears the speed window, the sums and the previous sample.
// Write config only while no item is in flight.
// Each component runs two 33-bit passes through one shared bit-serial divider
// (speed, then window average); a speed found to clip before dividing skips
// its pass. One item is processed at a time: the next transfer can be taken
// in the cycle after a result moves into the output register.
// Reset: window length 10, one component, window reads as all zero (one
// valid flop per window row), first item primes the previous sample.
// Stall: a held result stays in the output register; the core finishes the
// next item and then holds it, with input closed, until the register frees up.
module smoothed_rate_of_change_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_axis_tdata: value_x [31:0], value_y [63:32], value_z [95:64],
    //               delta_time [127:96]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sroc_pkg::IN_W-1:0]           s_axis_tdata,
    // m_axis_tdata: speed_x [31:0], speed_y [63:32], speed_z [95:64]
    // m_axis_tuser: saturated [0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sroc_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                                m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sroc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sroc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sroc_pkg::*;

    sroc_state_t state_reg, state_next;

    // Configuration
    logic [WIN_LEN_W-1:0]  win_len_reg;
    logic [COMP_CNT_W-1:0] comp_cnt_reg;
    logic [LEN_W-1:0]      eff_len;
    logic [CNT_W-1:0]      eff_cnt;

    // Sample history and window bookkeeping
    logic signed [DATA_W-1:0] now_reg  [COMPONENTS];
    logic signed [DATA_W-1:0] prev_reg [COMPONENTS];
    logic signed [SUM_W-1:0]  sum_reg  [COMPONENTS];
    logic [DATA_W-1:0]        res_reg  [COMPONENTS];
    logic [DATA_W-1:0]        dt_reg;
    logic                     primed_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_idx;
    logic [LEN_W-1:0]         pos_inc;
    logic [POS_W-1:0]         pos_next;

    // Speed window: one row holds every component's speed for one slot
    logic [ROW_W-1:0]      win_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] row_valid_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic                  rd_valid_reg;
    logic [ROW_W-1:0]      row_new_reg;

    // Per-component work registers
    logic [COMP_W-1:0]        c_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        speed_reg;
    logic                     sat_reg;

    // Output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic              m_user_reg;

    // Combinational
    logic                    in_acc;
    logic                    cfg_acc;
    logic                    rebuild;
    logic                    last_comp;
    logic                    out_load;
    logic [DATA_W-1:0]       old_word;
    logic [DATA_W:0]         abs_diff;
    logic                    q_ovf_early;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]        abs_sum;
    logic                    sat_pos;
    logic                    sat_neg;
    logic [DATA_W-1:0]       speed_q;
    logic [OUT_W-1:0]        out_data;

    sroc_div_req_t           div_req;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quot;

    sroc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign rebuild   = cfg_acc && (cfg_index == REG_WINDOW_LENGTH ||
                                   cfg_index == REG_COMPONENT_COUNT);

    // Zero acts as one, anything above the build limit acts as the limit.
    assign eff_len = (win_len_reg == '0) ? LEN_W'(1) :
                     (32'(win_len_reg) > WINDOW_MAX) ? LEN_W'(WINDOW_MAX) :
                     LEN_W'(win_len_reg);
    assign eff_cnt = (comp_cnt_reg == '0) ? CNT_W'(1) :
                     (32'(comp_cnt_reg) > COMPONENTS) ? CNT_W'(COMPONENTS) :
                     CNT_W'(comp_cnt_reg);

    assign pos_idx  = (LEN_W'(pos_reg) >= eff_len) ? '0 : pos_reg;
    assign pos_inc  = LEN_W'(pos_idx) + LEN_W'(1);
    assign pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];

    assign last_comp = ((CNT_W'(c_reg) + CNT_W'(1)) == eff_cnt);

    // A row never written since the last clear reads as zero.
    assign old_word = rd_valid_reg ? rd_row_reg[c_reg*DATA_W +: DATA_W] : '0;

    // Speed numerator is |diff| << 16. If its part above bit 32 already
    // reaches delta_time, the quotient cannot fit; clip without dividing.
    assign abs_diff    = diff_reg[DATA_W] ? DIV_W'(-diff_reg) : DIV_W'(diff_reg);
    assign q_ovf_early = ({{(DATA_W-FRAC_W){1'b0}}, abs_diff[DATA_W -: FRAC_W]} >= dt_reg);

    assign sum_sel = sum_reg[c_reg];
    assign abs_sum = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

    assign sat_pos = div_quot[DIV_W-1] | div_quot[DIV_W-2];
    assign sat_neg = div_quot[DIV_W-1] | (div_quot[DIV_W-2] & (|div_quot[DIV_W-3:0]));
    assign speed_q = neg_reg ? (sat_neg ? SPEED_MIN : -div_quot[DATA_W-1:0])
                             : (sat_pos ? SPEED_MAX : div_quot[DATA_W-1:0]);

    // Inactive lanes go out as zero.
    always_comb
    begin
        out_data = '0;
        for (int i = 0; i < COMPONENTS; i++)
        begin
            if (CNT_W'(i) < eff_cnt)
            begin
                out_data[i*DATA_W +: DATA_W] = res_reg[i];
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_LOAD;
            ST_LOAD:   state_next = (dt_reg == '0) ? ST_IDLE : ST_DIFF;
            ST_DIFF:   state_next = ST_QSTART;
            ST_QSTART: state_next = q_ovf_early ? ST_SUB : ST_QWAIT;
            ST_QWAIT:  if (div_done) state_next = ST_QDONE;
            ST_QDONE:  state_next = ST_SUB;
            ST_SUB:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_ASTART;
            ST_ASTART: state_next = ST_AWAIT;
            ST_AWAIT:  if (div_done) state_next = ST_ADONE;
            ST_ADONE:  state_next = last_comp ? ST_WRITE : ST_DIFF;
            ST_WRITE:  state_next = ST_PUSH;
            ST_PUSH:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control strobes and divider requests
    always_comb
    begin
        s_axis_tready    = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.rem_init = abs_diff[DATA_W -: FRAC_W];
        div_req.dividend = {abs_diff[DATA_W-FRAC_W:0], {FRAC_W{1'b0}}};
        div_req.divisor  = dt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_QSTART:
            begin
                div_req.start = !q_ovf_early;
            end
            ST_ASTART:
            begin
                // |sum| <= len * 2^31, so the upper part stays below len.
                div_req.start    = 1'b1;
                div_req.rem_init = REM_INIT_W'(abs_sum >> DIV_W);
                div_req.dividend = abs_sum[DIV_W-1:0];
                div_req.divisor  = DATA_W'(eff_len);
            end
            ST_PUSH:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control state, history and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= RESET_WINDOW_LENGTH;
            comp_cnt_reg  <= RESET_COMPONENT_COUNT;
            row_valid_reg <= '0;
            pos_reg       <= '0;
            primed_reg    <= 1'b0;
            c_reg         <= '0;
            neg_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < COMPONENTS; i++)
            begin
                prev_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:   win_len_reg  <= cfg_data[WIN_LEN_W-1:0];
                    REG_COMPONENT_COUNT: comp_cnt_reg <= cfg_data[COMP_CNT_W-1:0];
                    default:             ;
                endcase
            end

            if (rebuild)
            begin
                row_valid_reg <= '0;
                pos_reg       <= '0;
                primed_reg    <= 1'b0;
                for (int i = 0; i < COMPONENTS; i++)
                begin
                    prev_reg[i] <= '0;
                    sum_reg[i]  <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (in_acc)
                        begin
                            sat_reg <= 1'b0;
                        end
                    end
                    ST_LOAD:
                    begin
                        // First item primes itself; zero time only moves the sample.
                        c_reg <= '0;
                        if (dt_reg == '0 || !primed_reg)
                        begin
                            for (int i = 0; i < COMPONENTS; i++)
                            begin
                                prev_reg[i] <= now_reg[i];
                            end
                        end
                        if (dt_reg == '0)
                        begin
                            primed_reg <= 1'b1;
                        end
                    end
                    ST_QSTART:
                    begin
                        neg_reg <= diff_reg[DATA_W];
                        if (q_ovf_early)
                        begin
                            sat_reg <= 1'b1;
                        end
                    end
                    ST_QDONE:
                    begin
                        if (neg_reg ? sat_neg : sat_pos)
                        begin
                            sat_reg <= 1'b1;
                        end
                    end
                    ST_SUB:
                    begin
                        sum_reg[c_reg] <= sum_sel -
                            {{(SUM_W-DATA_W){old_word[DATA_W-1]}}, old_word};
                    end
                    ST_ADD:
                    begin
                        sum_reg[c_reg] <= sum_sel +
                            {{(SUM_W-DATA_W){speed_reg[DATA_W-1]}}, speed_reg};
                    end
                    ST_ASTART:
                    begin
                        neg_reg <= sum_sel[SUM_W-1];
                    end
                    ST_ADONE:
                    begin
                        c_reg <= c_reg + COMP_W'(1);
                    end
                    ST_WRITE:
                    begin
                        row_valid_reg[pos_idx] <= 1'b1;
                        pos_reg                <= pos_next;
                        primed_reg             <= 1'b1;
                        for (int i = 0; i < COMPONENTS; i++)
                        begin
                            prev_reg[i] <= now_reg[i];
                        end
                    end
                    default:
                    begin
                        primed_reg <= primed_reg;
                    end
                endcase
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dt_reg       <= s_axis_tdata[IN_W-1 -: DATA_W];
            rd_row_reg   <= win_mem[pos_idx];
            rd_valid_reg <= row_valid_reg[pos_idx];
            for (int i = 0; i < COMPONENTS; i++)
            begin
                now_reg[i] <= (CNT_W'(i) < eff_cnt) ? s_axis_tdata[i*DATA_W +: DATA_W] : '0;
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                row_new_reg <= '0;
            end
            ST_DIFF:
            begin
                diff_reg <= {now_reg[c_reg][DATA_W-1], now_reg[c_reg]} -
                            {prev_reg[c_reg][DATA_W-1], prev_reg[c_reg]};
            end
            ST_QSTART:
            begin
                if (q_ovf_early)
                begin
                    speed_reg <= diff_reg[DATA_W] ? SPEED_MIN : SPEED_MAX;
                end
            end
            ST_QDONE:
            begin
                speed_reg <= speed_q;
            end
            ST_ADD:
            begin
                row_new_reg[c_reg*DATA_W +: DATA_W] <= speed_reg;
            end
            ST_ADONE:
            begin
                // Average magnitude never exceeds 2^31, so 32 bits suffice.
                res_reg[c_reg] <= neg_reg ? -div_quot[DATA_W-1:0] : div_quot[DATA_W-1:0];
            end
            default:
            begin
                speed_reg <= speed_reg;
            end
        endcase

        if (out_load)
        begin
            m_data_reg <= out_data;
            m_user_reg <= sat_reg;
        end
    end

    // Window memory: one read at transfer time, one write at item end.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE && !rebuild)
        begin
            win_mem[pos_idx] <= row_new_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: design/sroc_checker.sv
`include "smoothed_rate_of_change_top_assert.svh"

module sroc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sroc_pkg::OUT_W-1:0]      m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [sroc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [sroc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sroc_pkg::*;

    logic [COMP_CNT_W-1:0] cnt_mirror_reg;
    logic                  in_acc;
    logic                  single_comp;
    logic                  out_stall;
    logic [OUT_W:0]        out_word;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign single_comp = (cnt_mirror_reg <= COMP_CNT_W'(1));
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_word    = {m_axis_tuser, m_axis_tdata};

    // Track the component count from the config channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_mirror_reg <= RESET_COMPONENT_COUNT;
        end
        else if (cfg_valid && cfg_ready && cfg_index == REG_COMPONENT_COUNT)
        begin
            cnt_mirror_reg <= cfg_data[COMP_CNT_W-1:0];
        end
    end

    // Scalar mode leaves the y and z lanes at zero.
    `SROC_ASSERT_NOW(a_scalar_lanes_zero, m_axis_tvalid && single_comp, m_axis_tdata[95:32] == '0)

    // One item at a time: input closes right after a transfer.
    `SROC_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)

    // A result never appears the cycle after its input transfer.
    `SROC_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(m_axis_tvalid))

    // A stalled result holds.
    `SROC_ASSERT_NEXT(a_stall_hold, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind smoothed_rate_of_change_top sroc_checker u_sroc_checker (.*);
